// File: hw/rtl/md5_digest_stream_defines.svh
// ----------------------------------------------------------------------------
// md5_digest_stream_defines
// assertion macros shared by the md5 digest stream checkers
// ----------------------------------------------------------------------------
`ifndef MD5_DIGEST_STREAM_DEFINES_SVH
`define MD5_DIGEST_STREAM_DEFINES_SVH

// same-cycle implication, disabled while reset is low
`define MD5DS_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled while reset is low
`define MD5DS_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: hw/rtl/md5ds_pkg.sv
// ----------------------------------------------------------------------------
// md5ds_pkg
// types, round constants and helper functions of the md5 digest stream
// ----------------------------------------------------------------------------
package md5ds_pkg;

    // input request: one message byte plus flags
    typedef struct packed {
        logic [7:0] data_byte;
        logic       byte_valid;
        logic       last_byte;
    } t_in_req;

    // output request: one half of the digest
    typedef struct packed {
        logic [63:0] digest_part;
        logic        digest_last;
    } t_out_req;

    // working or chaining words a, b, c, d
    typedef struct packed {
        logic [31:0] a;
        logic [31:0] b;
        logic [31:0] c;
        logic [31:0] d;
    } t_words;

    localparam t_words MD5_INIT = '{
        a: 32'h67452301,
        b: 32'hefcdab89,
        c: 32'h98badcfe,
        d: 32'h10325476
    };

    localparam logic [31:0] MD5_K [64] = '{
        32'hd76aa478, 32'he8c7b756, 32'h242070db, 32'hc1bdceee,
        32'hf57c0faf, 32'h4787c62a, 32'ha8304613, 32'hfd469501,
        32'h698098d8, 32'h8b44f7af, 32'hffff5bb1, 32'h895cd7be,
        32'h6b901122, 32'hfd987193, 32'ha679438e, 32'h49b40821,
        32'hf61e2562, 32'hc040b340, 32'h265e5a51, 32'he9b6c7aa,
        32'hd62f105d, 32'h02441453, 32'hd8a1e681, 32'he7d3fbc8,
        32'h21e1cde6, 32'hc33707d6, 32'hf4d50d87, 32'h455a14ed,
        32'ha9e3e905, 32'hfcefa3f8, 32'h676f02d9, 32'h8d2a4c8a,
        32'hfffa3942, 32'h8771f681, 32'h6d9d6122, 32'hfde5380c,
        32'ha4beea44, 32'h4bdecfa9, 32'hf6bb4b60, 32'hbebfbc70,
        32'h289b7ec6, 32'heaa127fa, 32'hd4ef3085, 32'h04881d05,
        32'hd9d4d039, 32'he6db99e5, 32'h1fa27cf8, 32'hc4ac5665,
        32'hf4292244, 32'h432aff97, 32'hab9423a7, 32'hfc93a039,
        32'h655b59c3, 32'h8f0ccc92, 32'hffeff47d, 32'h85845dd1,
        32'h6fa87e4f, 32'hfe2ce6e0, 32'ha3014314, 32'h4e0811a1,
        32'hf7537e82, 32'hbd3af235, 32'h2ad7d2bb, 32'heb86d391
    };

    localparam logic [4:0] MD5_S [16] = '{
        5'd7, 5'd12, 5'd17, 5'd22, 5'd5, 5'd9, 5'd14, 5'd20,
        5'd4, 5'd11, 5'd16, 5'd23, 5'd6, 5'd10, 5'd15, 5'd21
    };

    localparam logic [1:0] PHASE_F = 2'd0;
    localparam logic [1:0] PHASE_G = 2'd1;
    localparam logic [1:0] PHASE_H = 2'd2;
    localparam logic [1:0] PHASE_I = 2'd3;

    // message word used by a round
    function automatic logic [3:0] md5_msg_index(input logic [5:0] idx);
        logic [3:0] lo;
        logic [3:0] res;
        lo = idx[3:0];
        unique case (idx[5:4])
            PHASE_F: res = lo;
            PHASE_G: res = 4'(lo * 4'd5 + 4'd1);
            PHASE_H: res = 4'(lo * 4'd3 + 4'd5);
            PHASE_I: res = 4'(lo * 4'd7);
            default: res = lo;
        endcase
        return res;
    endfunction

    function automatic logic [4:0] md5_rot_amount(input logic [5:0] idx);
        return MD5_S[{idx[5:4], idx[1:0]}];
    endfunction

    function automatic logic [31:0] rotl32(input logic [31:0] x, input logic [4:0] n);
        logic [63:0] w;
        w = {x, x} << n;
        return w[63:32];
    endfunction

    function automatic logic [31:0] bswap32(input logic [31:0] x);
        return {x[7:0], x[15:8], x[23:16], x[31:24]};
    endfunction

    // word holding the 0x80 marker: lower bytes kept, upper bytes zero
    function automatic logic [31:0] pad_word(input logic [31:0] old, input logic [1:0] lane);
        logic [31:0] res;
        unique case (lane)
            2'd0:    res = 32'h0000_0080;
            2'd1:    res = {16'h0000, 8'h80, old[7:0]};
            2'd2:    res = {8'h00, 8'h80, old[15:0]};
            2'd3:    res = {8'h80, old[23:0]};
            default: res = 32'h0000_0080;
        endcase
        return res;
    endfunction

endpackage

// File: hw/rtl/md5ds_round.sv
// ----------------------------------------------------------------------------
// md5ds_round
// one md5 round: boolean function, add, rotate and word shuffle
// ----------------------------------------------------------------------------
module md5ds_round (
    input  md5ds_pkg::t_words i_words,
    input  logic [31:0]       i_km,
    input  logic [5:0]        i_idx,
    output md5ds_pkg::t_words o_words
);
    import md5ds_pkg::*;

    logic [31:0] w_f;
    logic [31:0] w_sum;
    logic [31:0] w_rot;

    always_comb begin
        unique case (i_idx[5:4])
            PHASE_F: w_f = (i_words.b & i_words.c) | (~i_words.b & i_words.d);
            PHASE_G: w_f = (i_words.d & i_words.b) | (~i_words.d & i_words.c);
            PHASE_H: w_f = i_words.b ^ i_words.c ^ i_words.d;
            PHASE_I: w_f = i_words.c ^ (i_words.b | ~i_words.d);
            default: w_f = i_words.b ^ i_words.c ^ i_words.d;
        endcase
    end

    // k + m comes precomputed from the r_km register
    assign w_sum = i_words.a + w_f + i_km;
    assign w_rot = rotl32(w_sum, md5_rot_amount(i_idx));

    assign o_words.a = i_words.d;
    assign o_words.b = i_words.b + w_rot;
    assign o_words.c = i_words.b;
    assign o_words.d = i_words.c;

endmodule

// File: hw/rtl/md5_digest_stream.sv
// ----------------------------------------------------------------------------
// md5_digest_stream
// byte-serial md5 hash with built-in padding and two-part digest output
// ----------------------------------------------------------------------------
// The block takes a message one byte per request (byte_valid marks a real
// byte, last_byte ends the message; an empty message is a single request with
// byte_valid low and last_byte high). Bytes land in a 16-word block buffer.
// The 64th byte of a block starts a compression on the single shared
// round unit: a setup step, the 64 rounds and an add into the chaining
// words, during all of which the input is not ready. At the end of a
// message the block pads the buffer (0x80, zeros, 64-bit little-endian
// bit length), then runs one compression, or two when fewer than nine
// bytes of room remain in the last block. The digest then leaves as two
// 64-bit output requests, printed byte order, first byte in the msb,
// digest_last set on the second. Once the second half is taken, the state
// returns to the md5 initial values and the next message may begin. Idle
// requests (no byte, no last) are taken and change nothing.
// ----------------------------------------------------------------------------
module md5_digest_stream (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  md5ds_pkg::t_in_req  i_in_req,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output md5ds_pkg::t_out_req o_out_req
);
    import md5ds_pkg::*;

    // sequencer states
    typedef enum logic [6:0] {
        S_IDLE  = 7'b0000001,
        S_PAD   = 7'b0000010,
        S_PRE   = 7'b0000100,
        S_ROUND = 7'b0001000,
        S_ADD   = 7'b0010000,
        S_OUT0  = 7'b0100000,
        S_OUT1  = 7'b1000000
    } t_state;

    t_state      r_state,     n_state;
    t_words      r_chain,     n_chain;
    t_words      r_round,     n_round;
    logic [63:0] r_count,     n_count;
    logic [5:0]  r_idx,       n_idx;
    logic [31:0] r_km,        n_km;
    logic        r_last_pend, n_last_pend;
    logic        r_final,     n_final;
    logic        r_zero_next, n_zero_next;

    // block buffer, written before read, so no reset
    logic [31:0] r_block [16];

    logic        w_in_fire;
    logic [5:0]  w_pos;
    logic [5:0]  w_km_idx;
    logic [31:0] w_km;
    logic        w_no_room;
    t_words      w_round_next;

    assign w_in_fire = i_in_valid && o_in_ready;
    // byte position inside the current block
    assign w_pos     = r_count[8:3];
    // length field would not fit after the marker
    assign w_no_room = (w_pos[5:3] == 3'b111);

    // k + m for the round that runs next cycle
    assign w_km_idx = (r_state == S_PRE) ? 6'd0 : r_idx + 6'd1;
    assign w_km     = MD5_K[w_km_idx] + r_block[md5_msg_index(w_km_idx)];

    md5ds_round u_round (
        .i_words (r_round),
        .i_km    (r_km),
        .i_idx   (r_idx),
        .o_words (w_round_next)
    );

    // handshake and digest output, driven straight from the chaining words
    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = (r_state == S_OUT0) || (r_state == S_OUT1);

    always_comb begin
        o_out_req.digest_last = (r_state == S_OUT1);
        if (r_state == S_OUT1) begin
            o_out_req.digest_part = {bswap32(r_chain.c), bswap32(r_chain.d)};
        end else begin
            o_out_req.digest_part = {bswap32(r_chain.a), bswap32(r_chain.b)};
        end
    end

    // sequencer
    always_comb begin
        n_state     = r_state;
        n_chain     = r_chain;
        n_round     = r_round;
        n_count     = r_count;
        n_idx       = r_idx;
        n_km        = r_km;
        n_last_pend = r_last_pend;
        n_final     = r_final;
        n_zero_next = r_zero_next;

        unique case (r_state)
            S_IDLE: begin
                if (w_in_fire) begin
                    n_last_pend = i_in_req.last_byte;
                    if (i_in_req.byte_valid) begin
                        n_count = r_count + 64'd8;
                    end
                    // a full block compresses before any padding
                    if (i_in_req.byte_valid && (w_pos == 6'd63)) begin
                        n_state = S_PRE;
                    end else if (i_in_req.last_byte) begin
                        n_state = S_PAD;
                    end
                end
            end
            S_PAD: begin
                if (w_no_room) begin
                    n_zero_next = 1'b1;
                end else begin
                    n_final = 1'b1;
                end
                n_state = S_PRE;
            end
            S_PRE: begin
                n_round = r_chain;
                n_idx   = 6'd0;
                n_km    = w_km;
                n_state = S_ROUND;
            end
            S_ROUND: begin
                n_round = w_round_next;
                n_idx   = r_idx + 6'd1;
                n_km    = w_km;
                if (r_idx == 6'd63) begin
                    n_state = S_ADD;
                end
            end
            S_ADD: begin
                n_chain.a = r_chain.a + r_round.a;
                n_chain.b = r_chain.b + r_round.b;
                n_chain.c = r_chain.c + r_round.c;
                n_chain.d = r_chain.d + r_round.d;
                priority if (r_final) begin
                    n_state = S_OUT0;
                end else if (r_zero_next) begin
                    // extra block holding only zeros and the length
                    n_zero_next = 1'b0;
                    n_final     = 1'b1;
                    n_state     = S_PRE;
                end else if (r_last_pend) begin
                    n_state = S_PAD;
                end else begin
                    n_state = S_IDLE;
                end
            end
            S_OUT0: begin
                if (i_out_ready) begin
                    n_state = S_OUT1;
                end
            end
            S_OUT1: begin
                if (i_out_ready) begin
                    // start over for the next message
                    n_chain     = MD5_INIT;
                    n_round     = '0;
                    n_count     = '0;
                    n_idx       = '0;
                    n_last_pend = 1'b0;
                    n_final     = 1'b0;
                    n_zero_next = 1'b0;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_chain     <= MD5_INIT;
            r_round     <= '0;
            r_count     <= '0;
            r_idx       <= '0;
            r_last_pend <= 1'b0;
            r_final     <= 1'b0;
            r_zero_next <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_chain     <= n_chain;
            r_round     <= n_round;
            r_count     <= n_count;
            r_idx       <= n_idx;
            r_last_pend <= n_last_pend;
            r_final     <= n_final;
            r_zero_next <= n_zero_next;
        end
    end

    always_ff @(posedge i_clk) begin
        r_km <= n_km;
    end

    // block buffer writes: byte store, padding, length-only block
    always_ff @(posedge i_clk) begin
        if (w_in_fire && i_in_req.byte_valid) begin
            r_block[w_pos[5:2]][{w_pos[1:0], 3'b000} +: 8] <= i_in_req.data_byte;
        end else if (r_state == S_PAD) begin
            for (int j = 0; j < 16; j++) begin
                if (4'(j) == w_pos[5:2]) begin
                    r_block[j] <= pad_word(r_block[j], w_pos[1:0]);
                end else if (4'(j) > w_pos[5:2]) begin
                    if (!w_no_room && (j == 14)) begin
                        r_block[j] <= r_count[31:0];
                    end else if (!w_no_room && (j == 15)) begin
                        r_block[j] <= r_count[63:32];
                    end else begin
                        r_block[j] <= '0;
                    end
                end
            end
        end else if ((r_state == S_ADD) && r_zero_next) begin
            for (int j = 0; j < 14; j++) begin
                r_block[j] <= '0;
            end
            r_block[14] <= r_count[31:0];
            r_block[15] <= r_count[63:32];
        end
    end

endmodule

// File: hw/rtl/md5ds_checker.sv
// ----------------------------------------------------------------------------
// md5ds_checker
// port-level checks of the md5 digest stream, bound to the top level
// ----------------------------------------------------------------------------
`include "md5_digest_stream_defines.svh"

module md5ds_checker (
    input logic                i_clk,
    input logic                i_rst_n,
    input logic                i_in_valid,
    input logic                o_in_ready,
    input md5ds_pkg::t_in_req  i_in_req,
    input logic                o_out_valid,
    input logic                i_out_ready,
    input md5ds_pkg::t_out_req o_out_req
);
    import md5ds_pkg::*;

    // waiting input request holds
    `MD5DS_ASSERT_NEXT(a_in_hold, i_clk, i_rst_n, i_in_valid && !o_in_ready, i_in_valid && $stable(i_in_req), "input request changed while waiting")

    // stalled digest half holds
    `MD5DS_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, o_out_valid && !i_out_ready, o_out_valid && $stable(o_out_req), "digest request changed while stalled")

    // no new request taken while a digest is pending
    `MD5DS_ASSERT_SAME(a_busy_out, i_clk, i_rst_n, o_out_valid, !o_in_ready, "input ready while digest pending")

    // first half is always followed by the second
    `MD5DS_ASSERT_NEXT(a_second_half, i_clk, i_rst_n, o_out_valid && i_out_ready && !o_out_req.digest_last, o_out_valid && o_out_req.digest_last, "second digest half missing")

    // after the second half the block is ready again
    `MD5DS_ASSERT_NEXT(a_ready_after, i_clk, i_rst_n, o_out_valid && i_out_ready && o_out_req.digest_last, o_in_ready && !o_out_valid, "block not ready after digest")

endmodule

bind md5_digest_stream md5ds_checker u_md5ds_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_ready  (o_in_ready),
    .i_in_req    (i_in_req),
    .o_out_valid (o_out_valid),
    .i_out_ready (i_out_ready),
    .o_out_req   (o_out_req)
);

// File: verif/tb.sv
// ----------------------------------------------------------------------------
// tb
// self-checking bench for the md5 digest stream
// ----------------------------------------------------------------------------
// Messages go in one byte per request and the two digest halves come back.
// An in-bench md5 calculator follows every accepted request and queues the
// halves it expects. Each half the block hands over is matched against the
// oldest queued one. Messages are mostly short, with some lengths sitting on
// the padding edges and a few spanning two or three blocks. Idle requests are
// mixed in, and both sides take random breaks. One long output hold-off
// backs the block up into its input.
// ----------------------------------------------------------------------------
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import md5ds_pkg::*;

    localparam int ITEM_TARGET   = 450;     // message-carrying requests
    localparam int MSG_TARGET    = 24;      // messages, two digest halves each
    localparam int HOLD_CYCLES   = 400;     // long output hold-off
    localparam int SETTLE_CYCLES = 200;     // covers two compressions and more
    localparam int CYCLE_LIMIT   = 400_000;

    // lengths around the padding and block edges
    localparam int EDGE_LEN [10] = '{55, 56, 57, 63, 64, 65, 119, 120, 127, 128};

    // ------------------------------------------------------------------------
    // md5 calculator: follows accepted requests, holds expected digest halves
    // ------------------------------------------------------------------------
    class md5_digest_calc;
        logic [31:0] chain [4];
        logic [31:0] blk [16];
        logic [63:0] bit_count;
        t_out_req    awaited_halves [$];
        int unsigned n_bytes;
        int unsigned n_messages;
        int unsigned n_halves;

        function new();
            n_bytes    = 0;
            n_messages = 0;
            n_halves   = 0;
            restart();
        endfunction

        function void restart();
            chain[0]  = MD5_INIT.a;
            chain[1]  = MD5_INIT.b;
            chain[2]  = MD5_INIT.c;
            chain[3]  = MD5_INIT.d;
            bit_count = '0;
            foreach (blk[k]) blk[k] = '0;
        endfunction

        // little-endian byte lanes within each block word
        function void set_byte(int pos, logic [7:0] v);
            blk[pos / 4][(pos % 4) * 8 +: 8] = v;
        endfunction

        function logic [31:0] swap_bytes(logic [31:0] x);
            return {x[7:0], x[15:8], x[23:16], x[31:24]};
        endfunction

        // 64 rounds over the current block, then add into the chain
        function void compress();
            logic [31:0] a, b, c, d, f, sum, hold;
            logic [3:0]  g;
            logic [5:0]  r;
            logic [4:0]  s;
            a = chain[0];
            b = chain[1];
            c = chain[2];
            d = chain[3];
            for (int i = 0; i < 64; i++) begin
                r = 6'(i);
                case (r[5:4])
                    PHASE_F: begin
                        f = (b & c) | (~b & d);
                        g = r[3:0];
                    end
                    PHASE_G: begin
                        f = (d & b) | (~d & c);
                        g = 4'(5 * i + 1);
                    end
                    PHASE_H: begin
                        f = b ^ c ^ d;
                        g = 4'(3 * i + 5);
                    end
                    default: begin
                        f = c ^ (b | ~d);
                        g = 4'(7 * i);
                    end
                endcase
                s    = MD5_S[{r[5:4], r[1:0]}];
                sum  = a + f + MD5_K[i] + blk[g];
                hold = d;
                d    = c;
                c    = b;
                b    = b + ((sum << s) | (sum >> (32 - s)));
                a    = hold;
            end
            chain[0] += a;
            chain[1] += b;
            chain[2] += c;
            chain[3] += d;
        endfunction

        function void take_request(t_in_req req);
            int pos;
            if (req.byte_valid) begin
                pos = int'(bit_count[8:3]);
                set_byte(pos, req.data_byte);
                bit_count += 64'd8;
                n_bytes++;
                if (pos == 63) compress();
            end
            if (!req.last_byte) return;

            // padding: marker, zeros, then the bit length, low word first
            pos = int'(bit_count[8:3]);
            set_byte(pos, 8'h80);
            for (int k = pos + 1; k < 64; k++) set_byte(k, 8'h00);
            if (pos >= 56) begin
                compress();
                foreach (blk[k]) blk[k] = '0;
            end
            blk[14] = bit_count[31:0];
            blk[15] = bit_count[63:32];
            compress();

            awaited_halves.push_back(t_out_req'{
                digest_part: {swap_bytes(chain[0]), swap_bytes(chain[1])},
                digest_last: 1'b0});
            awaited_halves.push_back(t_out_req'{
                digest_part: {swap_bytes(chain[2]), swap_bytes(chain[3])},
                digest_last: 1'b1});
            n_messages++;
            restart();
        endfunction

        // empty string when the half is as expected
        function string match_half(t_out_req got);
            t_out_req want;
            string    why;
            if (awaited_halves.size() == 0)
                return $sformatf("unexpected digest half %h last=%b",
                                 got.digest_part, got.digest_last);
            want = awaited_halves.pop_front();
            n_halves++;
            why = "";
            if (got.digest_part !== want.digest_part)
                why = {why, $sformatf(" digest_part got %h want %h",
                                      got.digest_part, want.digest_part)};
            if (got.digest_last !== want.digest_last)
                why = {why, $sformatf(" digest_last got %b want %b",
                                      got.digest_last, want.digest_last)};
            if (why != "") why = {$sformatf("digest half %0d:", n_halves), why};
            return why;
        endfunction
    endclass

    // ------------------------------------------------------------------------
    // signals and block
    // ------------------------------------------------------------------------
    logic     i_clk     = 1'b0;
    logic     i_rst_n   = 1'b0;
    logic     in_valid  = 1'b0;
    t_in_req  in_req    = '0;
    logic     out_ready = 1'b0;
    logic     in_ready;
    logic     out_valid;
    t_out_req out_req;

    md5_digest_stream dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (in_ready),
        .i_in_req    (in_req),
        .o_out_valid (out_valid),
        .i_out_ready (out_ready),
        .o_out_req   (out_req)
    );

    md5_digest_calc calc;

    int unsigned n_errors    = 0;
    int unsigned cycle_count = 0;
    int unsigned n_items     = 0;   // requests carrying a byte or an end
    bit          calm        = 1'b0;  // current message runs without breaks
    bit          quiet       = 1'b0;  // closing part of the run, no breaks
    bit          hold_req    = 1'b0;  // asks the output side for a long hold-off

    // ------------------------------------------------------------------------
    // clock, cycle count, watchdog
    // ------------------------------------------------------------------------
    initial begin
        forever #5 i_clk = ~i_clk;
    end

    always @(posedge i_clk) cycle_count <= cycle_count + 1;

    initial begin
        wait (cycle_count >= CYCLE_LIMIT);
        $display("timeout after %0d cycles, %0d digest halves still awaited",
                 cycle_count, calc.awaited_halves.size());
        $display("** md5_digest_stream: FAILED **");
        $finish;
    end

    task automatic report_mismatch(input string why);
        n_errors++;
        $display("mismatch at cycle %0d: %s", cycle_count, why);
    endtask

    // ------------------------------------------------------------------------
    // input side
    // ------------------------------------------------------------------------

    // offer one request at the falling edge, hold it until taken
    task automatic send_request(input t_in_req req);
        @(negedge i_clk);
        in_valid <= 1'b1;
        in_req   <= req;
        do @(posedge i_clk); while (in_ready !== 1'b1);
        calc.take_request(req);
        if (req.byte_valid || req.last_byte) n_items++;
    endtask

    // rest the input: valid held low, for a length set by n
    task automatic rest_input(input int n);
        @(negedge i_clk);
        in_valid <= 1'b0;
        repeat (n - 1) @(negedge i_clk);
    endtask

    task automatic maybe_rest();
        if (!calm && !quiet && $urandom_range(0, 7) == 0) rest_input($urandom_range(1, 13));
    endtask

    // sender pause until every digest half has come back
    task automatic wait_drained();
        @(negedge i_clk);
        in_valid <= 1'b0;
        while (calc.awaited_halves.size() != 0) @(posedge i_clk);
    endtask

    // random bytes; the end goes either on the last byte or on its own request
    task automatic send_message(input int len, input bit split_end);
        t_in_req req;
        for (int k = 0; k < len; k++) begin
            req.data_byte  = 8'($urandom_range(0, 255));
            req.byte_valid = 1'b1;
            req.last_byte  = (k == len - 1) && !split_end;
            maybe_rest();
            send_request(req);
            // stray idle request inside the message
            if (!quiet && $urandom_range(0, 24) == 0) begin
                req.data_byte  = 8'($urandom_range(0, 255));
                req.byte_valid = 1'b0;
                req.last_byte  = 1'b0;
                send_request(req);
            end
        end
        if (len == 0 || split_end) begin
            req.data_byte  = 8'($urandom_range(0, 255));
            req.byte_valid = 1'b0;
            req.last_byte  = 1'b1;
            maybe_rest();
            send_request(req);
        end
    endtask

    // mostly short messages, some on the padding edges, some multi-block
    function automatic int pick_length();
        int pick;
        pick = $urandom_range(0, 19);
        if (pick < 12) return $urandom_range(0, 12);
        if (pick < 15) return EDGE_LEN[$urandom_range(0, 9)];
        return $urandom_range(13, 80);
    endfunction

    // ------------------------------------------------------------------------
    // output side: random stalls, one long hold-off, checks at the rising edge
    // ------------------------------------------------------------------------
    initial begin
        int    stall_left;
        int    hold_left;
        bit    rdy;
        string why;
        stall_left = 0;
        hold_left  = 0;
        wait (i_rst_n === 1'b1);
        forever begin
            @(negedge i_clk);
            if (hold_req) begin
                hold_req  = 1'b0;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                rdy = 1'b0;
            end else if (stall_left > 0) begin
                stall_left--;
                rdy = 1'b0;
            end else if (!calm && !quiet && $urandom_range(0, 9) == 0) begin
                // start of a random burst of stalls, this one included
                stall_left = $urandom_range(0, 12);
                rdy = 1'b0;
            end else begin
                rdy = 1'b1;
            end
            out_ready <= rdy;
            @(posedge i_clk);
            if (out_valid === 1'b1 && out_ready) begin
                why = calc.match_half(out_req);
                if (why != "") report_mismatch(why);
            end
        end
    end

    // ------------------------------------------------------------------------
    // main sequence
    // ------------------------------------------------------------------------
    initial begin
        bit paused;
        paused = 1'b0;
        calc   = new();

        // synchronous reset, held low from time zero
        repeat (3) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // directed: empty message straight after reset
        send_request(t_in_req'{data_byte: 8'h00, byte_valid: 1'b0, last_byte: 1'b1});
        // idle request, then empty again with a junk byte that must be ignored
        send_request(t_in_req'{data_byte: 8'hff, byte_valid: 1'b0, last_byte: 1'b0});
        send_request(t_in_req'{data_byte: 8'hff, byte_valid: 1'b0, last_byte: 1'b1});
        // one-byte messages at both data extremes
        send_request(t_in_req'{data_byte: 8'h00, byte_valid: 1'b1, last_byte: 1'b1});
        rest_input(2);
        send_request(t_in_req'{data_byte: 8'hff, byte_valid: 1'b1, last_byte: 1'b1});
        // end marked on a request of its own
        send_request(t_in_req'{data_byte: 8'h5a, byte_valid: 1'b1, last_byte: 1'b0});
        send_request(t_in_req'{data_byte: 8'ha5, byte_valid: 1'b1, last_byte: 1'b0});
        send_request(t_in_req'{data_byte: 8'h00, byte_valid: 1'b0, last_byte: 1'b1});
        // idle request in the middle of a message
        send_request(t_in_req'{data_byte: 8'h11, byte_valid: 1'b1, last_byte: 1'b0});
        send_request(t_in_req'{data_byte: 8'h33, byte_valid: 1'b0, last_byte: 1'b0});
        send_request(t_in_req'{data_byte: 8'h22, byte_valid: 1'b1, last_byte: 1'b1});

        // long output hold-off while short messages keep coming: the digest
        // waits at the output and the input side has to stall behind it
        wait_drained();
        hold_req = 1'b1;
        repeat (3) send_message(3, 1'b0);
        wait_drained();

        // random messages; the closing stretch runs with no breaks
        while (n_items < ITEM_TARGET || calc.n_messages < MSG_TARGET) begin
            calm = ($urandom_range(0, 3) == 0);
            if (n_items >= ITEM_TARGET * 4 / 5) quiet = 1'b1;
            send_message(pick_length(), 1'($urandom_range(0, 1)));
            if (!paused && n_items >= ITEM_TARGET / 2) begin
                wait_drained();
                paused = 1'b1;
            end
        end

        // all in; wait for the last digest, then look for strays
        wait_drained();
        repeat (SETTLE_CYCLES) @(posedge i_clk);

        $display("covered %0d messages, %0d bytes, %0d requests; %0d digest halves checked",
                 calc.n_messages, calc.n_bytes, n_items, calc.n_halves);
        $display("incl. empty and edge-length messages, idle requests, stalls and a hold-off");
        if (n_errors == 0) begin
            $display("** md5_digest_stream: PASSED **");
        end else begin
            $display("** md5_digest_stream: FAILED **");
        end
        $finish;
    end

endmodule

// File: files.f
+incdir+hw/rtl
hw/rtl/md5ds_pkg.sv
hw/rtl/md5ds_round.sv
hw/rtl/md5_digest_stream.sv
hw/rtl/md5ds_checker.sv
verif/tb.sv
